// ----- design/scd_pkg.sv -----
// Package for the scan code to ASCII decoder: scan code constants, modifier
// flag positions, lookup control struct and the layout character tables.
// No dependencies.
package scd_pkg;

  // Scan code set 1 special bytes
  localparam logic [7:0] PREFIX_CODE = 8'hE0;
  localparam logic [7:0] LSHIFT_CODE = 8'h2A;
  localparam logic [7:0] RSHIFT_CODE = 8'h36;
  localparam logic [7:0] CTRL_CODE   = 8'h1D;
  localparam logic [7:0] ALT_CODE    = 8'h38;
  localparam logic [7:0] CAPS_CODE   = 8'h3A;
  localparam logic [7:0] RELEASE_BIT = 8'h80;

  // Modifier flag bit positions
  localparam int MOD_LSHIFT = 0;
  localparam int MOD_RSHIFT = 1;
  localparam int MOD_LCTRL  = 2;
  localparam int MOD_RCTRL  = 3;
  localparam int MOD_LALT   = 4;
  localparam int MOD_RALT   = 5;
  localparam int MOD_CAPS   = 6;
  localparam int MOD_WIDTH  = 7;

  // Codes covered by the tables; entries defined per table
  localparam int TABLE_ENTRIES = 128;
  localparam int TABLE_DEPTH   = 64;
  localparam int IDX_WIDTH     = $clog2(TABLE_DEPTH);

  localparam logic [6:0] CHAR_LOWER_A = 7'h61;
  localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;
  localparam logic [6:0] CASE_OFFSET  = 7'h20;

  typedef enum logic [1:0] {
    TBL_NORMAL = 2'd0,
    TBL_SHIFT  = 2'd1,
    TBL_ALTGR  = 2'd2
  } table_sel_t;

  typedef enum logic {
    LAYOUT_US = 1'b0,
    LAYOUT_PT = 1'b1
  } layout_t;

  // Lookup request from the key state tracker to the table lookup
  typedef struct packed {
    logic       lookup;
    table_sel_t table_sel;
    logic       caps;
  } key_ctrl_t;

  typedef logic [6:0] char_table_t [0:TABLE_DEPTH-1];

  localparam char_table_t US_NORMAL = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam char_table_t US_SHIFT = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam char_table_t PT_NORMAL = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h27, 7'h00, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h2B, 7'h00, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h00,
    7'h00, 7'h5C, 7'h00, 7'h7E, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2D, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam char_table_t PT_SHIFT = '{
    7'h00, 7'h00, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26,
    7'h2F, 7'h28, 7'h29, 7'h3D, 7'h3F, 7'h00, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h2A, 7'h60, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h00,
    7'h00, 7'h7C, 7'h00, 7'h5E, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3B, 7'h3A, 7'h5F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam char_table_t PT_ALTGR = '{
    7'h00, 7'h00, 7'h00, 7'h40, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h7B, 7'h5B, 7'h5D, 7'h7D, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

endpackage

// ----- design/scd_keystate.sv -----
// Key state tracker: extended-prefix flag and modifier flags, plus the
// classification of each byte into a table lookup request. Uses scd_pkg.
module scd_keystate (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       code,
  output scd_pkg::key_ctrl_t ctrl
);

  logic                          prefix;
  logic                          prefix_next;
  logic [scd_pkg::MOD_WIDTH-1:0] flags;
  logic [scd_pkg::MOD_WIDTH-1:0] flags_next;
  logic                          is_mod;
  logic                          ext;

  // Flag update for the byte being processed
  always_comb begin
    ext         = prefix;
    prefix_next = !ext && (code == scd_pkg::PREFIX_CODE);
    flags_next  = flags;
    is_mod      = 1'b1;
    case (code)
      scd_pkg::LSHIFT_CODE: flags_next[scd_pkg::MOD_LSHIFT] = 1'b1;
      scd_pkg::LSHIFT_CODE | scd_pkg::RELEASE_BIT:
        flags_next[scd_pkg::MOD_LSHIFT] = 1'b0;
      scd_pkg::RSHIFT_CODE: flags_next[scd_pkg::MOD_RSHIFT] = 1'b1;
      scd_pkg::RSHIFT_CODE | scd_pkg::RELEASE_BIT:
        flags_next[scd_pkg::MOD_RSHIFT] = 1'b0;
      scd_pkg::CTRL_CODE: begin
        if (ext) flags_next[scd_pkg::MOD_RCTRL] = 1'b1;
        else     flags_next[scd_pkg::MOD_LCTRL] = 1'b1;
      end
      scd_pkg::CTRL_CODE | scd_pkg::RELEASE_BIT: begin
        if (ext) flags_next[scd_pkg::MOD_RCTRL] = 1'b0;
        else     flags_next[scd_pkg::MOD_LCTRL] = 1'b0;
      end
      scd_pkg::ALT_CODE: begin
        if (ext) flags_next[scd_pkg::MOD_RALT] = 1'b1;
        else     flags_next[scd_pkg::MOD_LALT] = 1'b1;
      end
      scd_pkg::ALT_CODE | scd_pkg::RELEASE_BIT: begin
        if (ext) flags_next[scd_pkg::MOD_RALT] = 1'b0;
        else     flags_next[scd_pkg::MOD_LALT] = 1'b0;
      end
      scd_pkg::CAPS_CODE:
        flags_next[scd_pkg::MOD_CAPS] = !flags[scd_pkg::MOD_CAPS];
      default: is_mod = 1'b0;
    endcase
  end

  // Lookup request: make codes that are not modifiers, table from held keys
  always_comb begin
    ctrl.lookup = !is_mod && !code[7];
    ctrl.caps   = flags[scd_pkg::MOD_CAPS];
    if (flags[scd_pkg::MOD_LSHIFT] || flags[scd_pkg::MOD_RSHIFT]) begin
      ctrl.table_sel = scd_pkg::TBL_SHIFT;
    end else if (flags[scd_pkg::MOD_LALT] && flags[scd_pkg::MOD_RALT]) begin
      ctrl.table_sel = scd_pkg::TBL_ALTGR;
    end else begin
      ctrl.table_sel = scd_pkg::TBL_NORMAL;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= 1'b0;
      flags  <= '0;
    end else if (advance) begin
      prefix <= prefix_next;
      flags  <= flags_next;
    end
  end

endmodule

// ----- design/scd_lookup.sv -----
// Character table lookup with caps lock case fold on the normal table.
// Uses scd_pkg for the tables and the lookup control struct.
module scd_lookup #(
  parameter int TABLE_ENTRIES = scd_pkg::TABLE_ENTRIES
) (
  input  logic               layout,
  input  scd_pkg::key_ctrl_t ctrl,
  input  logic [6:0]         code,
  output logic               hit,
  output logic [6:0]         char_out
);

  logic [scd_pkg::IDX_WIDTH-1:0] idx;
  logic [6:0]                    entry;

  assign idx = code[scd_pkg::IDX_WIDTH-1:0];

  // Table read; codes past the defined rows or the table size read as zero
  always_comb begin
    entry = '0;
    if (code[6] == 1'b0 && 32'(code) < TABLE_ENTRIES) begin
      case (ctrl.table_sel)
        scd_pkg::TBL_NORMAL:
          entry = (layout == scd_pkg::LAYOUT_PT) ? scd_pkg::PT_NORMAL[idx]
                                                 : scd_pkg::US_NORMAL[idx];
        scd_pkg::TBL_SHIFT:
          entry = (layout == scd_pkg::LAYOUT_PT) ? scd_pkg::PT_SHIFT[idx]
                                                 : scd_pkg::US_SHIFT[idx];
        scd_pkg::TBL_ALTGR:
          entry = (layout == scd_pkg::LAYOUT_PT) ? scd_pkg::PT_ALTGR[idx] : 7'h00;
        default: entry = '0;
      endcase
    end
  end

  // Caps lock uppercases a-z from the normal table only
  always_comb begin
    char_out = entry;
    if (ctrl.table_sel == scd_pkg::TBL_NORMAL && ctrl.caps &&
        entry >= scd_pkg::CHAR_LOWER_A && entry <= scd_pkg::CHAR_LOWER_Z) begin
      char_out = entry - scd_pkg::CASE_OFFSET;
    end
    hit = ctrl.lookup && (entry != 7'h00);
  end

endmodule

// ----- design/scan_code_to_ascii_decoder_unit.sv -----
// Top level of the scan code set 1 to ASCII decoder: input and result
// registers, layout register and handshake. Uses scd_pkg, scd_keystate, scd_lookup.
//
//   channel   signals                        width  dir
//   input     in_valid in_ready scan_byte    8      in
//   result    out_valid out_ready char_code  7      out
//   config    cfg_we cfg_data (layout)       1      in
//
// One byte per cycle sustained while results are taken. A byte is held in the
// input register, then flag update and table lookup settle in one pass into
// the result register, which drives char_code. Synchronous reset clears
// flags, prefix and valids and selects the Portuguese layout. A stalled
// result holds the input register; the input still takes a byte whenever
// its register is empty or moving on.
module scan_code_to_ascii_decoder_unit #(
  parameter int TABLE_ENTRIES = scd_pkg::TABLE_ENTRIES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] scan_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] char_code,
  input  logic       cfg_we,
  input  logic       cfg_data
);

  logic               byte_valid;
  logic [7:0]         byte_reg;
  logic               layout;
  logic               advance;
  logic               hit;
  logic [6:0]         char_next;
  scd_pkg::key_ctrl_t ctrl;

  // Handshake: process the held byte whenever the result slot is free or being taken
  assign advance  = byte_valid && (!out_valid || out_ready);
  assign in_ready = !byte_valid || advance;

  // Layout register
  always_ff @(posedge clk) begin
    if (rst) begin
      layout <= scd_pkg::LAYOUT_PT;
    end else if (cfg_we) begin
      layout <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_reg <= scan_byte;
    end
  end

  scd_keystate u_keystate (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .code    (byte_reg),
    .ctrl    (ctrl)
  );

  scd_lookup #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_lookup (
    .layout   (layout),
    .ctrl     (ctrl),
    .code     (byte_reg[6:0]),
    .hit      (hit),
    .char_out (char_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      char_code <= char_next;
    end
  end

endmodule
